// File: rtl/hashed_occurrence_counter_core_assert.svh
`ifndef HASHED_OCCURRENCE_COUNTER_CORE_ASSERT_SVH
`define HASHED_OCCURRENCE_COUNTER_CORE_ASSERT_SVH

// property macros used at the end of the top level
`ifndef NO_ASSERTIONS

`define HOC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hoc check failed: consequent false");

`define HOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hoc check failed: next-cycle consequent false");

`else

`define HOC_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define HOC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/hoc_pkg.sv
package hoc_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [7:0]  NAME_SEP  = 8'h23;

    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_SEP  = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    localparam int FILL_W     = 14;
    localparam int CEIL_W     = 8;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FILL_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_CEILING = 2'd1;

    localparam logic [FILL_W-1:0] FILL_LIMIT_RST    = 14'd6144;
    localparam logic [CEIL_W-1:0] COUNT_CEILING_RST = 8'd250;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
    } key_push_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
    } queue_head_t;

    typedef struct packed {
        logic [31:0]       key;
        logic [CEIL_W-1:0] count;
    } slot_entry_t;

endpackage

// File: rtl/hoc_front.sv
module hoc_front
    import hoc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [1:0] action,
    input  logic [7:0] key_byte,
    input  logic      clearing,
    input  logic      q_full,
    output key_push_t push
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] folded;
    logic [7:0]  fold_byte;
    logic        accept;

    assign in_ready = !clearing && !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        fold_byte = (action == ACT_SEP) ? NAME_SEP : key_byte;
        folded    = 32'((hash_reg ^ 32'(fold_byte)) * FNV_PRIME);
        hash_next = hash_reg;
        push.valid = 1'b0;
        push.key   = (hash_reg == 32'd0) ? 32'd1 : hash_reg;
        case (action) inside
            ACT_BYTE, ACT_SEP:
            begin
                if (accept)
                    hash_next = folded;
            end
            ACT_END:
            begin
                if (accept)
                begin
                    push.valid = 1'b1;
                    hash_next  = FNV_BASIS;
                end
            end
            default:
            begin
                hash_next = hash_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_reg <= FNV_BASIS;
        else
            hash_reg <= hash_next;
    end

endmodule

// File: rtl/hoc_queue.sv
module hoc_queue
    import hoc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  key_push_t   push,
    output logic        q_full,
    output queue_head_t head,
    input  logic        pop
);

    logic [31:0]       q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign q_full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.key   = q_mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !q_full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem_reg[wr_ptr_reg] <= push.key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/hoc_back.sv
module hoc_back
    import hoc_pkg::*;
#(
    parameter int TABLE_DEPTH = 8192
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  queue_head_t       head,
    output logic              pop,
    input  logic [FILL_W-1:0] fill_limit,
    input  logic [CEIL_W-1:0] count_ceiling,
    output logic              clearing,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CEIL_W-1:0] seen_count,
    output logic              table_full
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;
    // rounded-up reciprocal of TABLE_DEPTH, used with a fix-up add so every
    // 32-bit key divides exactly
    localparam longint MAGIC_L = (((longint'(1) << IDX_W) - longint'(TABLE_DEPTH)) << 32)
                                 / longint'(TABLE_DEPTH) + 1;
    localparam logic [31:0]      MAGIC      = 32'(MAGIC_L);
    localparam logic [IDX_W-1:0] DEPTH_LO   = IDX_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_QUO,
        ST_REM,
        ST_READ,
        ST_CHECK
    } state_t;

    slot_entry_t table_mem [TABLE_DEPTH];
    slot_entry_t rd_data_reg;

    state_t            state_reg,  state_next;
    logic [IDX_W-1:0]  clr_reg,    clr_next;
    logic [31:0]       key_reg,    key_next;
    logic [31:0]       t1_reg,     t1_next;
    logic [IDX_W-1:0]  quo_reg,    quo_next;
    logic [IDX_W-1:0]  slot_reg,   slot_next;
    logic [CNT_W-1:0]  probe_reg,  probe_next;
    logic [CNT_W-1:0]  occ_reg,    occ_next;
    logic              out_valid_reg, out_valid_next;
    logic [CEIL_W-1:0] seen_reg,   seen_next;
    logic              full_reg,   full_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    slot_entry_t       mem_wdata;
    logic [31:0]       mul_hi;
    logic [IDX_W-1:0]  quo_lo;
    logic [IDX_W-1:0]  rem_calc;
    logic              hit;
    logic              empty;
    logic              at_limit;
    logic              out_free;
    logic [CEIL_W-1:0] bumped;

    assign clearing   = (state_reg == ST_CLEAR);
    assign out_valid  = out_valid_reg;
    assign seen_count = seen_reg;
    assign table_full = full_reg;

    // key mod TABLE_DEPTH in registered steps: high word of key * MAGIC,
    // quotient, then remainder from the low bits only
    assign mul_hi   = 32'(({32'd0, key_reg} * {32'd0, MAGIC}) >> 32);
    assign quo_lo   = IDX_W'((t1_reg + ((key_reg - t1_reg) >> 1)) >> (IDX_W - 1));
    assign rem_calc = key_reg[IDX_W-1:0] - quo_reg * DEPTH_LO;

    assign hit      = (rd_data_reg.key == key_reg);
    assign empty    = (rd_data_reg.key == 32'd0);
    assign at_limit = (CMP_W'(occ_reg) >= CMP_W'(fill_limit));
    assign out_free = !out_valid_reg || out_ready;
    assign bumped   = (rd_data_reg.count < count_ceiling) ? rd_data_reg.count + 1'b1
                                                          : rd_data_reg.count;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        key_next       = key_reg;
        t1_next        = t1_reg;
        quo_next       = quo_reg;
        slot_next      = slot_reg;
        probe_next     = probe_reg;
        occ_next       = occ_reg;
        seen_next      = seen_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    key_next   = head.key;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                t1_next    = mul_hi;
                state_next = ST_QUO;
            end
            ST_QUO:
            begin
                quo_next   = quo_lo;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                slot_next  = rem_calc;
                probe_next = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (hit || empty || probe_reg == LAST_PROBE)
                begin
                    // hold here until the result register frees up
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                        if (hit)
                        begin
                            mem_we          = 1'b1;
                            mem_wdata.key   = key_reg;
                            mem_wdata.count = bumped;
                            seen_next       = bumped;
                            full_next       = 1'b0;
                        end
                        else if (empty && !at_limit)
                        begin
                            mem_we          = 1'b1;
                            mem_wdata.key   = key_reg;
                            mem_wdata.count = CEIL_W'(1);
                            occ_next        = occ_reg + 1'b1;
                            seen_next       = CEIL_W'(1);
                            full_next       = 1'b0;
                        end
                        else
                        begin
                            seen_next = '0;
                            full_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= table_mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            key_reg       <= '0;
            t1_reg        <= '0;
            quo_reg       <= '0;
            slot_reg      <= '0;
            probe_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
            full_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            key_reg       <= key_next;
            t1_reg        <= t1_next;
            quo_reg       <= quo_next;
            slot_reg      <= slot_next;
            probe_reg     <= probe_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            seen_reg      <= seen_next;
            full_reg      <= full_next;
        end
    end

endmodule

// File: rtl/hashed_occurrence_counter_core.sv
// Counts occurrences of keys streamed in as bytes. Byte and separator words fold
// into a 32-bit FNV-1a hash at one word per cycle; an end-of-key word pushes the
// finished hash into a four-entry key queue, so the input keeps flowing while
// the table engine works. The engine pops each key from the queue, reduces the
// hash modulo TABLE_DEPTH by a reciprocal multiply (MUL, QUO and REM states),
// then reads and checks each probed slot (registered read of the table memory);
// the last probe waits while the previous result is still unread. Input stalls
// only when the key queue is full or while the table is being cleared.
// After reset the table is cleared one slot per cycle; no input word is taken
// during the clear. Configuration writes are taken at any time.
`include "hashed_occurrence_counter_core_assert.svh"

module hashed_occurrence_counter_core
    import hoc_pkg::*;
#(
    parameter int TABLE_DEPTH = 8192
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [7:0]            key_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CEIL_W-1:0]     seen_count,
    output logic                  table_full,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [FILL_W-1:0] fill_limit_reg;
    logic [CEIL_W-1:0] count_ceiling_reg;
    key_push_t         push;
    queue_head_t       head;
    logic              q_full;
    logic              pop;
    logic              clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_limit_reg    <= FILL_LIMIT_RST;
            count_ceiling_reg <= COUNT_CEILING_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FILL_LIMIT:    fill_limit_reg    <= cfg_data[FILL_W-1:0];
                REG_COUNT_CEILING: count_ceiling_reg <= cfg_data[CEIL_W-1:0];
                default:           fill_limit_reg    <= fill_limit_reg;
            endcase
        end
    end

    hoc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .key_byte (key_byte),
        .clearing (clearing),
        .q_full   (q_full),
        .push     (push)
    );

    hoc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .q_full (q_full),
        .head   (head),
        .pop    (pop)
    );

    hoc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .fill_limit    (fill_limit_reg),
        .count_ceiling (count_ceiling_reg),
        .clearing      (clearing),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .seen_count    (seen_count),
        .table_full    (table_full)
    );

    `HOC_ASSERT_IMP(a_full_means_zero, clk, rst_n, out_valid && table_full, seen_count == '0)
    `HOC_ASSERT_IMP(a_hit_counts, clk, rst_n, out_valid && !table_full, seen_count != '0)
    `HOC_ASSERT_IMP(a_no_result_in_clear, clk, rst_n, clearing, !out_valid && !in_ready)
    `HOC_ASSERT_NEXT(a_clear_no_pop, clk, rst_n, clearing, !$past(pop))

endmodule

// File: tb/hashed_occurrence_counter_core_tb.sv
`timescale 1ns / 1ps

module hashed_occurrence_counter_core_tb;
    import hoc_pkg::*;

    localparam int TBL_DEPTH     = 8192;
    localparam int SETTLE_CYCLES = 32;
    localparam int POOL_SIZE     = 8;

    localparam logic [1:0]           ACT_NONE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [CEIL_W-1:0] count;
        logic              full;
    } tally_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            action = ACT_BYTE;
    logic [7:0]            key_byte = 8'h00;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CEIL_W-1:0]     seen_count;
    logic                  table_full;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FILL_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the counter state
    logic [31:0]       run_hash;
    logic [31:0]       key_table [TBL_DEPTH];
    logic [CEIL_W-1:0] count_table [TBL_DEPTH];
    int unsigned       slots_used;
    logic [FILL_W-1:0] fill_limit_r;
    logic [CEIL_W-1:0] count_ceiling_r;

    tally_t pending_tallies[$];
    tally_t head_tally;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int errors = 0;
    int words_sent = 0;
    int results_checked = 0;
    int full_results = 0;

    logic [7:0] pool_bytes [POOL_SIZE][3];
    int         pool_len [POOL_SIZE];

    // lookup used while searching for a key that hashes to zero
    int          zero_t [65536];
    logic [23:0] zero_top [65536];

    hashed_occurrence_counter_core #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .key_byte   (key_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .seen_count (seen_count),
        .table_full (table_full),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d results still outstanding", $time, pending_tallies.size());
        $display("status: fail");
        $finish;
    end

    function automatic logic [31:0] fnv_fold(logic [31:0] h, logic [7:0] b);
        return (h ^ {24'd0, b}) * FNV_PRIME;
    endfunction

    task automatic tally_word(logic [1:0] act, logic [7:0] b);
        logic [31:0] key;
        int unsigned base;
        int unsigned slot;
        bit          done;
        tally_t      t;
        case (act)
            ACT_BYTE: run_hash = fnv_fold(run_hash, b);
            ACT_SEP:  run_hash = fnv_fold(run_hash, NAME_SEP);
            ACT_END:
            begin
                key = (run_hash == 32'd0) ? 32'd1 : run_hash;
                run_hash = FNV_BASIS;
                t.count = '0;
                t.full = 1'b1;
                done = 1'b0;
                base = key % TBL_DEPTH;
                for (int i = 0; i < TBL_DEPTH && !done; i++)
                begin
                    slot = (base + i) % TBL_DEPTH;
                    if (key_table[slot] == key)
                    begin
                        if (count_table[slot] < count_ceiling_r)
                            count_table[slot] = count_table[slot] + 1'b1;
                        t.count = count_table[slot];
                        t.full = 1'b0;
                        done = 1'b1;
                    end
                    else if (key_table[slot] == 32'd0)
                    begin
                        if (slots_used < fill_limit_r)
                        begin
                            key_table[slot] = key;
                            count_table[slot] = CEIL_W'(1);
                            slots_used++;
                            t.count = CEIL_W'(1);
                            t.full = 1'b0;
                        end
                        done = 1'b1;
                    end
                end
                pending_tallies.push_back(t);
            end
            default: ;
        endcase
    endtask

    task automatic send_word(logic [1:0] act, logic [7:0] b);
        // each cycle is idle with probability send_idle_pct
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        key_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tally_word(act, b);
        if (act != ACT_NONE)
            words_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_FILL_LIMIT)
            fill_limit_r = data;
        else if (idx == REG_COUNT_CEILING)
            count_ceiling_r = data[CEIL_W-1:0];
        @(posedge clk);
    endtask

    // stop offering words, wait for every result, then let the engine settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_tallies.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_name(int idx);
        for (int i = 0; i < pool_len[idx]; i++)
            send_word(ACT_BYTE, pool_bytes[idx][i]);
    endtask

    task automatic send_pool_key(int a, int b);
        send_name(a);
        send_word(ACT_SEP, 8'($urandom_range(0, 255)));
        send_name(b);
        send_word(ACT_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_key();
        repeat ($urandom_range(1, 4)) send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
        send_word(ACT_SEP, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 4)) send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
        send_word(ACT_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_short_key(logic [7:0] b);
        send_word(ACT_BYTE, b);
        send_word(ACT_SEP, 8'($urandom_range(0, 255)));
        send_word(ACT_END, 8'($urandom_range(0, 255)));
    endtask

    // five bytes whose hash is zero: choose the last two so the running value
    // drops to some t < 256 and then xors to zero
    task automatic find_zero_key(output logic [7:0] zk [5], output bit found);
        logic [31:0] pinv;
        logic [31:0] v;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] tv;
        int          idx;
        pinv = FNV_PRIME;
        repeat (5) pinv = pinv * (32'd2 - FNV_PRIME * pinv);
        for (int i = 0; i < 65536; i++)
            zero_t[i] = -1;
        for (int t = 0; t < 256; t++)
        begin
            tv = 32'(t);
            v = tv * pinv;
            zero_t[v[23:8]] = t;
            zero_top[v[23:8]] = v[31:8];
        end
        found = 1'b0;
        for (int p = 0; p < 256 && !found; p++)
            for (int b1 = 0; b1 < 256 && !found; b1++)
            begin
                h1 = fnv_fold(fnv_fold(FNV_BASIS, 8'(p)), 8'(b1));
                for (int b2 = 0; b2 < 256 && !found; b2++)
                begin
                    h2 = fnv_fold(h1, 8'(b2));
                    idx = int'(h2[23:8]);
                    if (zero_t[idx] >= 0 && zero_top[idx] == h2[31:8])
                    begin
                        tv = 32'(zero_t[idx]);
                        v = tv * pinv;
                        zk[0] = 8'(p);
                        zk[1] = 8'(b1);
                        zk[2] = 8'(b2);
                        zk[3] = h2[7:0] ^ v[7:0];
                        zk[4] = tv[7:0];
                        found = (fnv_fold(fnv_fold(h2, zk[3]), zk[4]) == 32'd0);
                    end
                end
            end
    endtask

    task automatic test_directed_basics();
        logic [7:0] zk [5];
        bit         found;
        find_zero_key(zk, found);
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 16383)));
        write_reg(REG_SPARE_B, 14'h3FFF);
        send_word(ACT_END, 8'hFF);                 // empty key
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_SEP, 8'hFF);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_END, 8'h00);
        // same key with unused actions mixed in
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_NONE, 8'hA5);
        send_word(ACT_SEP, 8'h5A);
        send_word(ACT_NONE, 8'h00);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_END, 8'h7F);
        if (found)
        begin
            for (int i = 0; i < 5; i++)
                send_word(ACT_BYTE, zk[i]);
            send_word(ACT_END, 8'($urandom_range(0, 255)));
        end
        else
            $display("%0t: note: no zero-hash key found, case skipped", $time);
        send_word(ACT_END, 8'h00);
        drain();
    endtask

    // keys that all start at the last slot, so probing wraps to slot 0
    task automatic test_probe_wrap();
        logic [7:0]  kb [3][2];
        logic [31:0] h;
        int          n;
        n = 0;
        for (int a = 0; a < 256 && n < 3; a++)
            for (int b = 0; b < 256 && n < 3; b++)
            begin
                h = fnv_fold(fnv_fold(FNV_BASIS, 8'(a)), 8'(b));
                if (h % TBL_DEPTH == TBL_DEPTH - 1)
                begin
                    kb[n][0] = 8'(a);
                    kb[n][1] = 8'(b);
                    n++;
                end
            end
        for (int k = 0; k < n; k++)
        begin
            send_word(ACT_BYTE, kb[k][0]);
            send_word(ACT_BYTE, kb[k][1]);
            send_word(ACT_END, 8'($urandom_range(0, 255)));
        end
        if (n > 0)
        begin
            send_word(ACT_BYTE, kb[n-1][0]);
            send_word(ACT_BYTE, kb[n-1][1]);
            send_word(ACT_END, 8'($urandom_range(0, 255)));
        end
        drain();
    endtask

    task automatic test_fill_limit();
        write_reg(REG_FILL_LIMIT, '0);
        repeat (3) send_random_key();
        send_word(ACT_END, 8'($urandom_range(0, 255)));     // known key still hits
        drain();
        write_reg(REG_FILL_LIMIT, CFG_DATA_W'(slots_used + 2));
        repeat (4) send_random_key();
        drain();
        write_reg(REG_FILL_LIMIT, 14'h3FFF);
        send_random_key();
        drain();
        write_reg(REG_FILL_LIMIT, CFG_DATA_W'(TBL_DEPTH));
    endtask

    task automatic test_count_ceiling();
        logic [7:0] k1;
        logic [7:0] hot;
        k1 = 8'($urandom_range(0, 255));
        hot = 8'($urandom_range(0, 255));
        write_reg(REG_COUNT_CEILING, 14'd1);
        repeat (3) send_short_key(k1);
        drain();
        // high bits dropped: ceiling becomes 0
        write_reg(REG_COUNT_CEILING, 14'h3F00);
        repeat (2) send_short_key(k1 ^ 8'h55);
        send_short_key(k1);
        drain();
        write_reg(REG_COUNT_CEILING, 14'd3);
        repeat (5) send_short_key(k1 ^ 8'hAA);
        drain();
        // count already above the new ceiling stays where it is
        write_reg(REG_COUNT_CEILING, 14'd2);
        send_short_key(k1 ^ 8'hAA);
        drain();
        write_reg(REG_COUNT_CEILING, 14'd255);
        repeat (258)
        begin
            send_word(ACT_BYTE, hot);
            send_word(ACT_END, 8'($urandom_range(0, 255)));
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (12) send_random_key();
        drain();
    endtask

    task automatic test_random_traffic(int n_words, logic [CFG_DATA_W-1:0] fill,
                                       logic [CFG_DATA_W-1:0] ceiling);
        int stop_at;
        int r;
        write_reg(REG_FILL_LIMIT, fill);
        write_reg(REG_COUNT_CEILING, ceiling);
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 78)
                send_pool_key($urandom_range(0, POOL_SIZE - 1), $urandom_range(0, POOL_SIZE - 1));
            else if (r < 86)
                send_random_key();
            else if (r < 93)
                send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else
            begin
                // malformed: missing or doubled separator
                send_name($urandom_range(0, POOL_SIZE - 1));
                if (r < 96)
                begin
                    send_word(ACT_SEP, 8'($urandom_range(0, 255)));
                    send_word(ACT_SEP, 8'($urandom_range(0, 255)));
                end
                send_name($urandom_range(0, POOL_SIZE - 1));
                send_word(ACT_END, 8'($urandom_range(0, 255)));
            end
        end
        drain();
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tallies.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing pending: expected none, actual count %0d full %0b",
                         $time, seen_count, table_full);
            end
            else
            begin
                head_tally = pending_tallies.pop_front();
                results_checked++;
                if (head_tally.full)
                    full_results++;
                if (seen_count !== head_tally.count)
                begin
                    errors++;
                    $display("%0t: seen_count mismatch: expected %0d, actual %0d",
                             $time, head_tally.count, seen_count);
                end
                if (table_full !== head_tally.full)
                begin
                    errors++;
                    $display("%0t: table_full mismatch: expected %0b, actual %0b",
                             $time, head_tally.full, table_full);
                end
            end
        end
    end

    initial
    begin
        run_hash = FNV_BASIS;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            key_table[i] = '0;
            count_table[i] = '0;
        end
        slots_used = 0;
        fill_limit_r = FILL_LIMIT_RST;
        count_ceiling_r = COUNT_CEILING_RST;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_len[i] = $urandom_range(1, 3);
            for (int j = 0; j < 3; j++)
                pool_bytes[i][j] = 8'($urandom_range(0, 255));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 59;
        test_directed_basics();
        test_probe_wrap();
        test_fill_limit();
        test_count_ceiling();
        test_backpressure();
        test_random_traffic(270, 14'h3FFF, CFG_DATA_W'($urandom_range(2, 12)));

        send_idle_pct = 59;
        recv_idle_pct = 29;
        test_random_traffic(270, CFG_DATA_W'(slots_used + $urandom_range(10, 40)),
                            CFG_DATA_W'($urandom_range(1, 12)));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(270, CFG_DATA_W'(TBL_DEPTH), 14'd255);

        $display("summary: %0d words sent, %0d results checked, %0d refused as table full",
                 words_sent, results_checked, full_results);
        $display("summary: %0d slots in use; fill limit and count ceiling swept incl. extremes",
                 slots_used);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
